[sv/hls_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hls_pkg
// Shared widths, types and codes of the Holt linear smoother.
// ----------------------------------------------------------------------------
package hls_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int FRAC_BITS       = 8;
    localparam int STATE_WIDTH     = SAMPLE_WIDTH + FRAC_BITS + 2;
    localparam int GAIN_WIDTH      = 16;
    localparam int GAIN_FRAC       = 15;
    localparam int GAIN_ONE        = 32768;
    localparam int OPND_WIDTH      = STATE_WIDTH + 1;
    localparam int PROD_WIDTH      = OPND_WIDTH + GAIN_WIDTH + 1;
    localparam int ACC_WIDTH       = PROD_WIDTH + 1;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int GAIN_RESET      = 16384;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [STATE_WIDTH-1:0]  state_t;
    typedef logic        [GAIN_WIDTH-1:0]   gain_t;
    typedef logic signed [OPND_WIDTH-1:0]   opnd_t;
    typedef logic signed [PROD_WIDTH-1:0]   prod_t;
    typedef logic signed [ACC_WIDTH-1:0]    acc_t;
    typedef logic [CFG_INDEX_WIDTH-1:0]     cfg_index_t;
    typedef logic [1:0]                     seen_t;

    localparam cfg_index_t CFG_LEVEL_GAIN = 1'd0;
    localparam cfg_index_t CFG_TREND_GAIN = 1'd1;

    localparam seen_t SEEN_NONE = 2'd0;
    localparam seen_t SEEN_ONE  = 2'd1;
    localparam seen_t SEEN_TWO  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_T,
        ST_MUL_D,
        ST_FINISH
    } ctrl_state_t;

    // operand pair fed to the shared multiplier
    typedef enum logic [1:0] {
        MUL_X_ALPHA,
        MUL_LT_INV_ALPHA,
        MUL_T_INV_BETA,
        MUL_DIFF_BETA
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     prime;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_load;
        logic     level_update;
        logic     trend_update;
        logic     out_pass;
        logic     out_smooth;
    } cmd_t;

endpackage

[sv/hls_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hls_sample_if / hls_smoothed_if
// Valid/ready channels carrying one sample word or one smoothed word.
// ----------------------------------------------------------------------------
interface hls_sample_if;
    logic             valid;
    logic             ready;
    hls_pkg::sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface hls_smoothed_if;
    logic             valid;
    logic             ready;
    hls_pkg::sample_t smoothed;

    modport source (output valid, output smoothed, input ready);
    modport sink (input valid, input smoothed, output ready);
endinterface

[sv/hls_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hls_ctrl
// Sequencer: handshakes, sample count and the multiply schedule.
// ----------------------------------------------------------------------------
module hls_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output hls_pkg::cmd_t cmd
);

    hls_pkg::ctrl_state_t state_reg, state_next;
    hls_pkg::seen_t       seen_reg, seen_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hls_pkg::ST_IDLE;
            seen_reg      <= hls_pkg::SEEN_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == hls_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            hls_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (seen_reg == hls_pkg::SEEN_TWO) ? hls_pkg::ST_MUL_A
                                                                  : hls_pkg::ST_PASS;
                end
            end
            hls_pkg::ST_PASS:
            begin
                // first two words pass straight through; the second primes the state
                if (out_free)
                begin
                    cmd.out_pass   = 1'b1;
                    cmd.prime      = (seen_reg == hls_pkg::SEEN_ONE);
                    seen_next      = (seen_reg == hls_pkg::SEEN_NONE) ? hls_pkg::SEEN_ONE
                                                                      : hls_pkg::SEEN_TWO;
                    out_valid_next = 1'b1;
                    state_next     = hls_pkg::ST_IDLE;
                end
            end
            hls_pkg::ST_MUL_A:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = hls_pkg::MUL_X_ALPHA;
                state_next  = hls_pkg::ST_MUL_B;
            end
            hls_pkg::ST_MUL_B:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = hls_pkg::MUL_LT_INV_ALPHA;
                cmd.acc_load = 1'b1;
                state_next   = hls_pkg::ST_MUL_T;
            end
            hls_pkg::ST_MUL_T:
            begin
                cmd.mul_en       = 1'b1;
                cmd.mul_sel      = hls_pkg::MUL_T_INV_BETA;
                cmd.level_update = 1'b1;
                state_next       = hls_pkg::ST_MUL_D;
            end
            hls_pkg::ST_MUL_D:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = hls_pkg::MUL_DIFF_BETA;
                cmd.acc_load = 1'b1;
                state_next   = hls_pkg::ST_FINISH;
            end
            hls_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.trend_update = 1'b1;
                    cmd.out_smooth   = 1'b1;
                    out_valid_next   = 1'b1;
                    state_next       = hls_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hls_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[sv/hls_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hls_datapath
// Gains, smoother state, one shared multiplier with accumulator, output word.
// ----------------------------------------------------------------------------
module hls_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  hls_pkg::cmd_t       cmd,
    input  hls_pkg::sample_t    sample,
    output hls_pkg::sample_t    smoothed,
    input  logic                cfg_we,
    input  hls_pkg::cfg_index_t cfg_index,
    input  hls_pkg::gain_t      cfg_data
);

    localparam int Q_WIDTH   = hls_pkg::ACC_WIDTH - hls_pkg::GAIN_FRAC;
    localparam int R_WIDTH   = hls_pkg::STATE_WIDTH + 1;
    localparam int O_WIDTH   = R_WIDTH - hls_pkg::FRAC_BITS;
    localparam int EXT_X     = hls_pkg::OPND_WIDTH - hls_pkg::SAMPLE_WIDTH
                               - hls_pkg::FRAC_BITS;
    localparam int EXT_L     = hls_pkg::STATE_WIDTH - hls_pkg::SAMPLE_WIDTH
                               - hls_pkg::FRAC_BITS;
    localparam int EXT_T     = hls_pkg::STATE_WIDTH - hls_pkg::SAMPLE_WIDTH - 1
                               - hls_pkg::FRAC_BITS;
    localparam hls_pkg::gain_t GAIN_ONE_G = hls_pkg::gain_t'(hls_pkg::GAIN_ONE);
    localparam hls_pkg::acc_t  ROUND_HALF =
        hls_pkg::acc_t'(2 ** (hls_pkg::GAIN_FRAC - 1));
    localparam logic signed [R_WIDTH-1:0] OUT_HALF =
        R_WIDTH'(2 ** (hls_pkg::FRAC_BITS - 1));

    hls_pkg::gain_t   level_gain_reg, trend_gain_reg, cfg_gain;
    hls_pkg::sample_t x_reg, last_reg;
    hls_pkg::state_t  level_reg, trend_reg, old_level_reg;
    hls_pkg::prod_t   prod_reg, acc_reg, prod_next;
    hls_pkg::sample_t smoothed_reg, smoothed_next;
    hls_pkg::opnd_t   opnd_a;
    hls_pkg::gain_t   opnd_g;
    logic signed [hls_pkg::GAIN_WIDTH:0] opnd_gs;
    hls_pkg::state_t  blend_sat, prime_level, prime_trend;
    hls_pkg::acc_t    blend_sum;
    logic signed [Q_WIDTH-1:0] blend_q;
    logic signed [R_WIDTH-1:0] out_round;
    logic signed [O_WIDTH-1:0] out_q;
    logic signed [hls_pkg::SAMPLE_WIDTH:0] prime_diff;

    // gain above one acts as one
    assign cfg_gain = (cfg_data > GAIN_ONE_G) ? GAIN_ONE_G : cfg_data;

    always_comb
    begin
        case (cmd.mul_sel)
            hls_pkg::MUL_X_ALPHA:
            begin
                opnd_a = {{EXT_X{x_reg[hls_pkg::SAMPLE_WIDTH-1]}}, x_reg,
                          {hls_pkg::FRAC_BITS{1'b0}}};
                opnd_g = level_gain_reg;
            end
            hls_pkg::MUL_LT_INV_ALPHA:
            begin
                opnd_a = {level_reg[hls_pkg::STATE_WIDTH-1], level_reg}
                       + {trend_reg[hls_pkg::STATE_WIDTH-1], trend_reg};
                opnd_g = GAIN_ONE_G - level_gain_reg;
            end
            hls_pkg::MUL_T_INV_BETA:
            begin
                opnd_a = {trend_reg[hls_pkg::STATE_WIDTH-1], trend_reg};
                opnd_g = GAIN_ONE_G - trend_gain_reg;
            end
            hls_pkg::MUL_DIFF_BETA:
            begin
                opnd_a = {level_reg[hls_pkg::STATE_WIDTH-1], level_reg}
                       - {old_level_reg[hls_pkg::STATE_WIDTH-1], old_level_reg};
                opnd_g = trend_gain_reg;
            end
            default:
            begin
                opnd_a = '0;
                opnd_g = '0;
            end
        endcase
    end

    assign opnd_gs   = {1'b0, opnd_g};
    assign prod_next = hls_pkg::prod_t'(opnd_a) * hls_pkg::prod_t'(opnd_gs);

    // round half up at the gain point, then clamp to the state range
    assign blend_sum = hls_pkg::acc_t'(acc_reg) + hls_pkg::acc_t'(prod_reg) + ROUND_HALF;
    assign blend_q   = Q_WIDTH'(blend_sum >>> hls_pkg::GAIN_FRAC);

    always_comb
    begin
        if (&blend_q[Q_WIDTH-1:hls_pkg::STATE_WIDTH-1]
            || ~|blend_q[Q_WIDTH-1:hls_pkg::STATE_WIDTH-1])
            blend_sat = blend_q[hls_pkg::STATE_WIDTH-1:0];
        else if (blend_q[Q_WIDTH-1])
            blend_sat = {1'b1, {(hls_pkg::STATE_WIDTH-1){1'b0}}};
        else
            blend_sat = {1'b0, {(hls_pkg::STATE_WIDTH-1){1'b1}}};
    end

    assign prime_diff  = {x_reg[hls_pkg::SAMPLE_WIDTH-1], x_reg}
                       - {last_reg[hls_pkg::SAMPLE_WIDTH-1], last_reg};
    assign prime_level = {{EXT_L{x_reg[hls_pkg::SAMPLE_WIDTH-1]}}, x_reg,
                          {hls_pkg::FRAC_BITS{1'b0}}};
    assign prime_trend = {{EXT_T{prime_diff[hls_pkg::SAMPLE_WIDTH]}}, prime_diff,
                          {hls_pkg::FRAC_BITS{1'b0}}};

    // output: level rounded to integer, clamped to the sample range
    assign out_round = {level_reg[hls_pkg::STATE_WIDTH-1], level_reg} + OUT_HALF;
    assign out_q     = O_WIDTH'(out_round >>> hls_pkg::FRAC_BITS);

    always_comb
    begin
        if (cmd.out_pass)
            smoothed_next = x_reg;
        else if (&out_q[O_WIDTH-1:hls_pkg::SAMPLE_WIDTH-1]
                 || ~|out_q[O_WIDTH-1:hls_pkg::SAMPLE_WIDTH-1])
            smoothed_next = out_q[hls_pkg::SAMPLE_WIDTH-1:0];
        else if (out_q[O_WIDTH-1])
            smoothed_next = {1'b1, {(hls_pkg::SAMPLE_WIDTH-1){1'b0}}};
        else
            smoothed_next = {1'b0, {(hls_pkg::SAMPLE_WIDTH-1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_gain_reg <= hls_pkg::gain_t'(hls_pkg::GAIN_RESET);
            trend_gain_reg <= hls_pkg::gain_t'(hls_pkg::GAIN_RESET);
            level_reg      <= '0;
            trend_reg      <= '0;
            last_reg       <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == hls_pkg::CFG_LEVEL_GAIN)
                level_gain_reg <= cfg_gain;
            if (cfg_we && cfg_index == hls_pkg::CFG_TREND_GAIN)
                trend_gain_reg <= cfg_gain;
            if (cmd.prime)
            begin
                level_reg <= prime_level;
                trend_reg <= prime_trend;
            end
            else
            begin
                if (cmd.level_update)
                    level_reg <= blend_sat;
                if (cmd.trend_update)
                    trend_reg <= blend_sat;
            end
            if (cmd.out_pass || cmd.out_smooth)
                last_reg <= x_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            x_reg <= sample;
        if (cmd.mul_en)
            prod_reg <= prod_next;
        if (cmd.acc_load)
            acc_reg <= prod_reg;
        if (cmd.level_update)
            old_level_reg <= level_reg;
        if (cmd.out_pass || cmd.out_smooth)
            smoothed_reg <= smoothed_next;
    end

    assign smoothed = smoothed_reg;

endmodule

[sv/holt_linear_smoother.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// holt_linear_smoother
// Holt level-plus-trend smoother of a signed sample stream, one word per word.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch   : valid/ready input, one signed sample per word.
//   smoothed_ch : valid/ready output, one smoothed word per input word.
//   cfg_we/cfg_index/cfg_data : gain writes, index 0 level gain (alpha),
//     index 1 trend gain (beta), Q1.15; values above 1.0 act as 1.0.
//     Write only while the block is idle.
// Sequence:
//   The first two words after reset pass through: the result word is
//   registered in the PASS state once the output register is free. Later
//   words step through MUL_A, MUL_B, MUL_T, MUL_D and FINISH: four passes
//   through the single shared 27x17 multiplier, with the level and trend
//   blends folded into the accumulate steps.
//   One word in flight at a time: a new word is taken the cycle after the
//   previous result is loaded.
// Reset: gains return to 0.5, level, trend and sample count to zero.
// Stall: a result waits in the output register; the next word is accepted
//   and computed meanwhile, and its result is held until that register drains.
// ----------------------------------------------------------------------------
module holt_linear_smoother (
    input  logic                clk,
    input  logic                rst_n,
    hls_sample_if.sink          sample_ch,
    hls_smoothed_if.source      smoothed_ch,
    input  logic                cfg_we,
    input  hls_pkg::cfg_index_t cfg_index,
    input  hls_pkg::gain_t      cfg_data
);

    hls_pkg::cmd_t cmd;

    hls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_ch.valid),
        .in_ready  (sample_ch.ready),
        .out_valid (smoothed_ch.valid),
        .out_ready (smoothed_ch.ready),
        .cmd       (cmd)
    );

    hls_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample    (sample_ch.sample),
        .smoothed  (smoothed_ch.smoothed),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // a result word is only loaded when the output register is free
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_pass || cmd.out_smooth) |-> (!smoothed_ch.valid || smoothed_ch.ready))
        else $error("result loaded over an untaken word");

    // at most one of capture / pass / smooth result per cycle
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.out_pass, cmd.out_smooth}))
        else $error("conflicting sequencer commands");

    // one word in flight: no acceptance right after an acceptance
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_ch.valid && sample_ch.ready) |=> !sample_ch.ready)
        else $error("second word accepted while busy");

    // level blend is followed by the trend product load
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.level_update |=> (cmd.acc_load && cmd.mul_sel == hls_pkg::MUL_DIFF_BETA))
        else $error("multiply schedule out of order");

endmodule
